// File: hw/rtl/bphf_pkg.sv
// ----------------------------------------------------------------------------
// bphf_pkg
// Shared constants, codes and controller/datapath interface types for the
// black pixel hole fill core.
// ----------------------------------------------------------------------------
package bphf_pkg;

  // default sizes
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int HEIGHT_LIMIT   = 1024;
  localparam int ROW_W          = $clog2(HEIGHT_LIMIT);

  // register port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_center;
    logic check;
    logic win_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_req;
    logic fill;
    logic win_last;
    logic div_run;
    logic div_last;
    logic out_free;
    logic settle;
  } sts_t;

endpackage

// File: hw/rtl/black_pixel_hole_fill_core.sv
// ----------------------------------------------------------------------------
// black_pixel_hole_fill_core
// Streaming hole filler: replaces interior pure-black pixels by the mean of
// their non-black neighbors (color) or by 255/0 (gray).
// ----------------------------------------------------------------------------
// One item is handled at a time. A released pixel goes through the center
// read and the check to the output register; a black interior pixel adds
// (2r+1)^2 window reads on the single line-store read port, an accumulate
// step, a divide init and, in color mode when the count test passes, a
// restoring divide. Input stalls in the cycle after every register write.
// Any register write restarts the frame; the line store is not cleared,
// since every location read for an output pixel has been written earlier in
// the same frame.
module black_pixel_hole_fill_core
  import bphf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [7:0]            chan0,
  input  logic [7:0]            chan1,
  input  logic [7:0]            chan2,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_chan0,
  output logic [7:0]            out_chan1,
  output logic [7:0]            out_chan2,
  output logic                  frame_end
);

  cmd_t cmd;
  sts_t sts;

  bphf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bphf_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .opcode    (opcode),
    .chan0     (chan0),
    .chan1     (chan1),
    .chan2     (chan2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_chan0 (out_chan0),
    .out_chan1 (out_chan1),
    .out_chan2 (out_chan2),
    .frame_end (frame_end),
    .cmd       (cmd),
    .sts       (sts)
  );

  // an item that releases a pixel blocks the input while it is worked
  a_busy_after_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.emit_req) |=> in_stall)
    else $error("input open while a pixel is in work");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

  // output valid only rises from a load
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid without a load");

endmodule

// File: hw/rtl/bphf_ctrl.sv
// ----------------------------------------------------------------------------
// bphf_ctrl
// Sequencer: takes one item, then walks the center read, window scan and
// divide (where needed) and output hand-off for any pixel that the item releases.
// ----------------------------------------------------------------------------
module bphf_ctrl
  import bphf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READC = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WIN   = 3'd3;
  localparam logic [2:0] ST_WACC  = 3'd4;
  localparam logic [2:0] ST_DINIT = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE) || sts.settle;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          if (sts.emit_req) state_next = ST_READC;
        end
      end
      ST_READC: begin
        cmd.rd_center = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_next = sts.fill ? ST_WIN : ST_OUT;
      end
      ST_WIN: begin
        cmd.win_step = 1'b1;
        if (sts.win_last) state_next = ST_WACC;
      end
      ST_WACC: begin
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = sts.div_run ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/bphf_dpath.sv
// ----------------------------------------------------------------------------
// bphf_dpath
// Datapath: config registers, frame counters, line store, window
// accumulators, three restoring dividers and the output register.
// ----------------------------------------------------------------------------
module bphf_dpath
  import bphf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  opcode,
  input  logic [7:0]            chan0,
  input  logic [7:0]            chan1,
  input  logic [7:0]            chan2,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_chan0,
  output logic [7:0]            out_chan1,
  output logic [7:0]            out_chan2,
  output logic                  frame_end,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int XW     = COL_W + 1;
  localparam int ROWS   = 2 * MAX_RADIUS + 1;
  localparam int RMOD_W = $clog2(ROWS);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int SPAN_W = RAD_W + 1;
  localparam int WIN_N  = ROWS * ROWS;
  localparam int WN_W   = $clog2(WIN_N + 1);
  localparam int SUM_W  = $clog2(WIN_N * 255 + 1);
  localparam int DI_W   = $clog2(SUM_W);
  localparam int CNT_W  = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
  localparam int ADDR_W = RMOD_W + COL_W;
  localparam int DEPTH  = ROWS * (2 ** COL_W);

  // configuration
  logic                  gray_mode;
  logic [1:0]            radius;
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic                  settle;

  logic [XW-1:0]         w_eff;
  logic [CFG_DATA_W-1:0] h_eff;
  logic [RAD_W-1:0]      r_eff;
  logic [CNT_W-1:0]      total;
  logic [CNT_W-1:0]      lag;

  // frame position
  logic [CNT_W-1:0]  in_cnt;
  logic [COL_W-1:0]  in_col;
  logic [RMOD_W-1:0] in_rmod;
  logic [CNT_W-1:0]  out_cnt;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [RMOD_W-1:0] out_rmod;

  // line store
  logic [23:0]       mem [DEPTH];
  logic [23:0]       q;
  logic [ADDR_W-1:0] rd_addr;
  logic              take;

  // window scan
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] ri;
  logic [SPAN_W-1:0] ci;
  logic [RMOD_W-1:0] wrow;
  logic [COL_W-1:0]  wcol;
  logic [COL_W-1:0]  wcol0;
  logic [RMOD_W-1:0] wrow0;
  logic              acc_pend;
  logic              q_black;
  logic [SUM_W-1:0]  sum [3];
  logic [WN_W-1:0]   cnt;
  logic [WN_W-1:0]   thr;
  logic              pass;

  // dividers
  logic [SUM_W-1:0]  quo [3];
  logic [WN_W-1:0]   rem [3];
  logic [SUM_W-1:0]  quo_next [3];
  logic [WN_W-1:0]   rem_next [3];
  logic [DI_W-1:0]   div_i;

  // result
  logic [7:0]        res [3];
  logic              interior;
  logic              last_out;

  // effective frame geometry
  always_comb begin
    if (frame_width == '0) w_eff = XW'(1);
    else if (int'(frame_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(frame_width);
    if (frame_height == '0) h_eff = CFG_DATA_W'(1);
    else if (int'(frame_height) > HEIGHT_LIMIT) h_eff = CFG_DATA_W'(HEIGHT_LIMIT);
    else h_eff = frame_height;
    if (int'(radius) > MAX_RADIUS) r_eff = RAD_W'(MAX_RADIUS);
    else r_eff = RAD_W'(radius);
  end

  // config registers and registered frame totals
  always_ff @(posedge clk) begin
    if (rst) begin
      gray_mode    <= 1'b0;
      radius       <= 2'd1;
      frame_width  <= CFG_DATA_W'(640);
      frame_height <= CFG_DATA_W'(480);
      settle       <= 1'b1;
    end else begin
      settle <= wr_en;
      if (wr_en) begin
        case (wr_index)
          REG_GRAY_MODE:    gray_mode    <= wr_data[0];
          REG_RADIUS:       radius       <= wr_data[1:0];
          REG_FRAME_WIDTH:  frame_width  <= wr_data;
          REG_FRAME_HEIGHT: frame_height <= wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    total <= CNT_W'(int'(w_eff) * int'(h_eff));
    lag   <= CNT_W'(int'(r_eff) * int'(w_eff) + int'(r_eff));
  end

  // item decision
  assign take = (opcode == OP_PIXEL) && (in_cnt < total);
  assign last_out = ({1'b0, out_cnt} + 1'b1) >= {1'b0, total};

  assign sts.emit_req = take
                      ? (({1'b0, in_cnt} + 1'b1) > ({1'b0, out_cnt} + {1'b0, lag}))
                      : (in_cnt >= total);

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || wr_en || (cmd.load_out && last_out)) begin
      in_cnt   <= '0;
      in_col   <= '0;
      in_rmod  <= '0;
      out_cnt  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_rmod <= '0;
    end else begin
      if (cmd.accept && take) begin
        in_cnt <= in_cnt + 1'b1;
        if (XW'(in_col) + 1'b1 == w_eff) begin
          in_col  <= '0;
          in_rmod <= (in_rmod == RMOD_W'(ROWS - 1)) ? '0 : in_rmod + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_cnt <= out_cnt + 1'b1;
        if (XW'(out_col) + 1'b1 == w_eff) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_rmod <= (out_rmod == RMOD_W'(ROWS - 1)) ? '0 : out_rmod + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // line store: one write port, one registered read port
  assign rd_addr = cmd.win_step ? {wrow, wcol} : {out_rmod, out_col};

  always_ff @(posedge clk) begin
    if (cmd.accept && take) mem[{in_rmod, in_col}] <= {chan2, chan1, chan0};
    if (cmd.rd_center || cmd.win_step) q <= mem[rd_addr];
  end

  // center pixel tests
  assign q_black  = gray_mode ? (q[7:0] == 8'd0) : (q == 24'd0);
  assign interior = ({1'b0, out_row} >= (CFG_DATA_W)'(r_eff))
                 && ((CFG_DATA_W+1)'(out_row) + (CFG_DATA_W+1)'(r_eff) < {1'b0, h_eff})
                 && ((XW+1)'(out_col) >= (XW+1)'(r_eff))
                 && ((XW+1)'(out_col) + (XW+1)'(r_eff) < {1'b0, w_eff});
  assign sts.fill = q_black && interior;

  // window start and scan limits
  assign span  = SPAN_W'(2 * int'(r_eff));
  assign wcol0 = out_col - COL_W'(r_eff);
  assign wrow0 = (out_rmod >= RMOD_W'(r_eff)) ? out_rmod - RMOD_W'(r_eff)
               : RMOD_W'(int'(out_rmod) + ROWS - int'(r_eff));
  assign sts.win_last = (ri == span) && (ci == span);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
    end else begin
      acc_pend <= cmd.win_step;
    end
  end

  // window walk and accumulation
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      ri   <= '0;
      ci   <= '0;
      wrow <= wrow0;
      wcol <= wcol0;
      cnt  <= '0;
      for (int k = 0; k < 3; k++) sum[k] <= '0;
    end else begin
      if (cmd.win_step) begin
        if (ci == span) begin
          ci   <= '0;
          wcol <= wcol0;
          ri   <= ri + 1'b1;
          wrow <= (wrow == RMOD_W'(ROWS - 1)) ? '0 : wrow + 1'b1;
        end else begin
          ci   <= ci + 1'b1;
          wcol <= wcol + 1'b1;
        end
      end
      if (acc_pend && !q_black) begin
        cnt <= cnt + 1'b1;
        for (int k = 0; k < 3; k++) sum[k] <= sum[k] + SUM_W'(q[8*k +: 8]);
      end
    end
  end

  // count test against (r+1) squared
  assign thr  = WN_W'((int'(r_eff) + 1) * (int'(r_eff) + 1));
  assign pass = (cnt >= thr) && (cnt != '0);
  assign sts.div_run  = pass && !gray_mode;
  assign sts.div_last = (div_i == DI_W'(SUM_W - 1));

  // restoring divide step, one quotient bit per cycle for each channel
  always_comb begin
    logic [WN_W:0] sh;
    for (int k = 0; k < 3; k++) begin
      sh = {rem[k], quo[k][SUM_W-1]};
      if (sh >= {1'b0, cnt}) begin
        rem_next[k] = WN_W'(sh - {1'b0, cnt});
        quo_next[k] = {quo[k][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[k] = sh[WN_W-1:0];
        quo_next[k] = {quo[k][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_i <= '0;
      for (int k = 0; k < 3; k++) begin
        quo[k] <= sum[k];
        rem[k] <= '0;
      end
    end else if (cmd.div_step) begin
      div_i <= div_i + 1'b1;
      for (int k = 0; k < 3; k++) begin
        quo[k] <= quo_next[k];
        rem[k] <= rem_next[k];
      end
    end
  end

  // result value
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res[0] <= q[7:0];
      res[1] <= gray_mode ? 8'd0 : q[15:8];
      res[2] <= gray_mode ? 8'd0 : q[23:16];
    end else if (cmd.div_init && !sts.div_run) begin
      res[0] <= (gray_mode && pass) ? 8'd255 : 8'd0;
      res[1] <= 8'd0;
      res[2] <= 8'd0;
    end else if (cmd.div_step && sts.div_last) begin
      for (int k = 0; k < 3; k++) res[k] <= quo_next[k][7:0];
    end
  end

  // output register
  assign sts.out_free = !out_valid || !out_stall;
  assign sts.settle   = settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_chan0 <= res[0];
      out_chan1 <= res[1];
      out_chan2 <= res[2];
      frame_end <= last_out;
    end
  end

endmodule
